// File: hw/rtl/idp_pkg.sv
package idp_pkg;

    localparam int WORD_W    = 32;
    localparam int WORD_BITS = 5;
    localparam int ID_W      = 8;
    localparam int STATUS_W  = 2;

    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BEYOND       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED    = 2'd3;

    localparam logic [1:0] RD_ZERO        = 2'd0;
    localparam logic [1:0] RD_ID          = 2'd1;
    localparam logic [1:0] RD_SCAN_NEXT   = 2'd2;
    localparam logic [1:0] RD_SHRINK_NEXT = 2'd3;

    typedef struct packed {
        logic       clear;
        logic       fresh;
        logic       beyond;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       scan_init;
        logic       scan_next;
        logic       latch_id;
        logic       grant;
        logic       already;
        logic       set_bit;
        logic       shrink;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic free_zero;
        logic beyond;
        logic word_nz;
        logic bit_set;
        logic id_top;
        logic shrink_more;
    } t_stat;

    function automatic logic [WORD_BITS-1:0] lo_pos(input logic [WORD_W-1:0] v);
        logic [WORD_BITS-1:0] pos;
        pos = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                pos = WORD_BITS'(i);
            end
        end
        return pos;
    endfunction

    function automatic logic [WORD_BITS-1:0] hi_pos(input logic [WORD_W-1:0] v);
        logic [WORD_BITS-1:0] pos;
        pos = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                pos = WORD_BITS'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: hw/rtl/idp_ctrl.sv
module idp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_opcode,
    input  idp_pkg::t_stat i_stat,
    output idp_pkg::t_cmd  o_cmd,
    output logic          busy
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_SHRNK = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    idp_pkg::t_cmd cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_opcode == idp_pkg::OP_ALLOC) begin
                        if (i_stat.free_zero) begin
                            cmd.fresh = 1'b1;
                        end else begin
                            cmd.rd_en     = 1'b1;
                            cmd.rd_sel    = idp_pkg::RD_ZERO;
                            cmd.scan_init = 1'b1;
                            n_state       = S_SCAN;
                        end
                    end else begin
                        if (i_stat.beyond) begin
                            cmd.beyond = 1'b1;
                        end else begin
                            cmd.rd_en    = 1'b1;
                            cmd.rd_sel   = idp_pkg::RD_ID;
                            cmd.latch_id = 1'b1;
                            n_state      = S_CHECK;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.word_nz) begin
                    cmd.grant = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    cmd.scan_next = 1'b1;
                    cmd.rd_en     = 1'b1;
                    cmd.rd_sel    = idp_pkg::RD_SCAN_NEXT;
                end
            end
            S_CHECK: begin
                if (i_stat.bit_set) begin
                    cmd.already = 1'b1;
                    n_state     = S_IDLE;
                end else if (!i_stat.id_top) begin
                    cmd.set_bit = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    cmd.shrink = 1'b1;
                    if (i_stat.shrink_more) begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = idp_pkg::RD_SHRINK_NEXT;
                        n_state    = S_SHRNK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SHRNK: begin
                cmd.shrink = 1'b1;
                if (i_stat.shrink_more) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = idp_pkg::RD_SHRINK_NEXT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd = cmd;
    assign busy  = (r_state != S_IDLE);

endmodule

// File: hw/rtl/idp_dpath.sv
module idp_dpath #(
    parameter int POOL_SIZE = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  idp_pkg::t_cmd                   i_cmd,
    input  logic [idp_pkg::ID_W-1:0]        i_release_id,
    output idp_pkg::t_stat                  o_stat,
    output logic                            o_done,
    output logic [idp_pkg::ID_W-1:0]        o_granted_id,
    output logic [idp_pkg::STATUS_W-1:0]    o_status
);

    localparam int WW    = idp_pkg::WORD_W;
    localparam int WB    = idp_pkg::WORD_BITS;
    localparam int IW    = idp_pkg::ID_W;
    localparam int MW    = $clog2(POOL_SIZE + 1);
    localparam int DEPTH = (POOL_SIZE + WW - 1) / WW;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WW-1:0] mem [0:DEPTH-1];
    logic [WW-1:0] r_rdata;
    logic [AW-1:0] r_clr;
    logic [AW-1:0] r_scan;
    logic [MW-1:0] r_mark;
    logic [MW-1:0] r_count;
    logic [IW-1:0] r_id;
    logic          r_first;
    logic          r_done;
    logic [IW-1:0] r_gid;
    logic [idp_pkg::STATUS_W-1:0] r_status;

    logic [MW-1:0] n_mark;
    logic [MW-1:0] n_count;
    logic          done_now;
    logic [IW-1:0] gid_now;
    logic [idp_pkg::STATUS_W-1:0] status_now;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [WW-1:0] wr_data;
    logic [AW-1:0] rd_addr;

    logic [MW-1:0]       top;
    logic [AW+MW+4:0]    top_ext;
    logic [AW-1:0]       top_word;
    logic [WB-1:0]       top_bit;
    logic [AW+IW+4:0]    id_ext;
    logic [AW-1:0]       id_word;
    logic [AW+IW+4:0]    rid_ext;
    logic [AW-1:0]       rid_word;
    logic [WW-1:0]       shr_data;
    logic [WW-1:0]       le_mask;
    logic [WW-1:0]       zeros;
    logic                z_found;
    logic [WB-1:0]       z_pos;
    logic [WW-1:0]       keep_mask;
    logic [AW+MW+5:0]    shr_mark_wide;
    logic [MW-1:0]       shr_mark;
    logic [WB-1:0]       lo_bit;
    logic [AW+IW+4:0]    grant_wide;
    logic [MW+IW-1:0]    fresh_wide;
    logic                exhausted;

    assign top      = r_mark - MW'(1);
    assign top_ext  = {{(AW + 5){1'b0}}, top};
    assign top_word = top_ext[AW+WB-1:WB];
    assign top_bit  = top_ext[WB-1:0];
    assign id_ext   = {{(AW + 5){1'b0}}, i_release_id};
    assign id_word  = id_ext[AW+WB-1:WB];
    assign rid_ext  = {{(AW + 5){1'b0}}, r_id};
    assign rid_word = rid_ext[AW+WB-1:WB];

    assign shr_data  = r_rdata | (r_first ? (WW'(1) << top_bit) : '0);
    assign le_mask   = {WW{1'b1}} >> (WB'(WW - 1) - top_bit);
    assign zeros     = ~shr_data & le_mask;
    assign z_found   = |zeros;
    assign z_pos     = idp_pkg::hi_pos(zeros);
    assign keep_mask = {WW{1'b1}} >> (WB'(WW - 1) - z_pos);
    assign shr_mark_wide = z_found ? ({{(MW + 1){1'b0}}, top_word, z_pos} + (AW + MW + 6)'(1))
                                   : {{(MW + 1){1'b0}}, top_word, {WB{1'b0}}};
    assign shr_mark  = shr_mark_wide[MW-1:0];

    assign lo_bit     = idp_pkg::lo_pos(r_rdata);
    assign grant_wide = {{IW{1'b0}}, r_scan, lo_bit};
    assign fresh_wide = {{IW{1'b0}}, r_mark};
    assign exhausted  = (r_mark == MW'(POOL_SIZE));

    assign o_stat.clr_last    = (r_clr == AW'(DEPTH - 1));
    assign o_stat.free_zero   = (r_count == '0);
    assign o_stat.beyond      = ({{MW{1'b0}}, i_release_id} >= {{IW{1'b0}}, r_mark});
    assign o_stat.word_nz     = (r_rdata != '0);
    assign o_stat.bit_set     = r_rdata[r_id[WB-1:0]];
    assign o_stat.id_top      = ({{MW{1'b0}}, r_id} == {{IW{1'b0}}, top});
    assign o_stat.shrink_more = !z_found && (top_word != '0);

    always_comb begin
        case (i_cmd.rd_sel)
            idp_pkg::RD_ZERO:        rd_addr = '0;
            idp_pkg::RD_ID:          rd_addr = id_word;
            idp_pkg::RD_SCAN_NEXT:   rd_addr = r_scan + AW'(1);
            idp_pkg::RD_SHRINK_NEXT: rd_addr = top_word - AW'(1);
            default:                 rd_addr = '0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = '0;
        if (i_cmd.clear) begin
            wr_en = 1'b1;
        end else if (i_cmd.grant) begin
            wr_en   = 1'b1;
            wr_addr = r_scan;
            wr_data = r_rdata & ~(WW'(1) << lo_bit);
        end else if (i_cmd.set_bit) begin
            wr_en   = 1'b1;
            wr_addr = rid_word;
            wr_data = r_rdata | (WW'(1) << r_id[WB-1:0]);
        end else if (i_cmd.shrink) begin
            wr_en   = 1'b1;
            wr_addr = top_word;
            wr_data = z_found ? (shr_data & keep_mask) : '0;
        end
    end

    always_comb begin
        n_mark     = r_mark;
        n_count    = r_count;
        done_now   = 1'b0;
        gid_now    = '0;
        status_now = idp_pkg::ST_OK;
        if (i_cmd.fresh) begin
            done_now = 1'b1;
            if (exhausted) begin
                status_now = idp_pkg::ST_EXHAUSTED;
            end else begin
                gid_now = fresh_wide[IW-1:0];
                n_mark  = r_mark + MW'(1);
            end
        end
        if (i_cmd.beyond) begin
            done_now   = 1'b1;
            status_now = idp_pkg::ST_BEYOND;
        end
        if (i_cmd.grant) begin
            done_now = 1'b1;
            gid_now  = grant_wide[IW-1:0];
            n_count  = r_count - MW'(1);
        end
        if (i_cmd.already) begin
            done_now   = 1'b1;
            status_now = idp_pkg::ST_ALREADY_FREE;
        end
        if (i_cmd.set_bit) begin
            done_now = 1'b1;
            n_count  = r_count + MW'(1);
        end
        if (i_cmd.shrink) begin
            done_now = !o_stat.shrink_more;
            n_mark   = shr_mark;
            n_count  = r_count + MW'(r_first) - (r_mark - shr_mark);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_mark  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr <= r_clr + AW'(1);
            end
            r_mark  <= n_mark;
            r_count <= n_count;
            r_done  <= done_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_init) begin
            r_scan <= '0;
        end else if (i_cmd.scan_next) begin
            r_scan <= r_scan + AW'(1);
        end
        if (i_cmd.latch_id) begin
            r_id <= i_release_id;
        end
        r_first  <= i_cmd.latch_id;
        r_gid    <= gid_now;
        r_status <= status_now;
    end

    assign o_done       = r_done;
    assign o_granted_id = r_gid;
    assign o_status     = r_status;

endmodule

// File: hw/rtl/id_pool_allocator.sv
// Channel   Signals                              Transfer
// -------   ----------------------------------   --------------------------------
// request   start, busy, i_opcode, i_release_id   edge with start high, busy low
// result    o_done, o_granted_id, o_status       edge ending the cycle o_done is high
//
// After reset the bitmap memory is cleared one 32-bit word per cycle, with busy high.
// For an allocate with no freed ID, and any release at or beyond the mark, the
// result appears in the cycle after the transfer. An allocate of a freed ID reads
// one bitmap word per cycle from word zero up to the first nonzero word. A release
// reads its ID's word, then sets its bit or reports it already free; releasing the
// top ID lowers the mark instead, stepping down through words of only freed IDs.
// Each step uses the single bitmap memory port pair. The receiver cannot stall.
module id_pool_allocator #(
    parameter int POOL_SIZE = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_opcode,
    input  logic [idp_pkg::ID_W-1:0]     i_release_id,
    output logic                         o_done,
    output logic [idp_pkg::ID_W-1:0]     o_granted_id,
    output logic [idp_pkg::STATUS_W-1:0] o_status
);

    idp_pkg::t_cmd  cmd;
    idp_pkg::t_stat stat;

    idp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    idp_dpath #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_release_id (i_release_id),
        .o_stat       (stat),
        .o_done       (o_done),
        .o_granted_id (o_granted_id),
        .o_status     (o_status)
    );

endmodule
